/* hdl/eobd_pkg.sv */
// ----------------------------------------------------------------------------
// eobd_pkg
// shared types and constants for the eye openness blink detector
// ----------------------------------------------------------------------------
package eobd_pkg;

    localparam int COORD_BITS_DEF = 12;     // default coordinate width
    localparam int POINT_W        = 24;     // packed point width
    localparam int NUM_POINTS     = 6;      // landmarks per request
    localparam int IN_DATA_W      = NUM_POINTS * POINT_W;
    localparam int Q16_W          = 17;     // openness and threshold width
    localparam int OUT_DATA_W     = 24;     // openness + blink, padded to bytes
    localparam int STEP_W         = 5;      // iteration counter width
    localparam int DIV_STEPS      = Q16_W;  // one quotient bit per step

    localparam logic [Q16_W-1:0] THRESH_RESET = 17'd13107;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SUM,
        ST_ROOT,
        ST_STORE,
        ST_ORDER,
        ST_DIV,
        ST_DONE
    } state_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQX,
        OP_SQY,
        OP_SUM,
        OP_ROOT,
        OP_STORE,
        OP_ORDER,
        OP_DIV
    } op_t;

    // which point pair the distance is taken over
    typedef enum logic [1:0] {
        PAIR_H1,
        PAIR_H2,
        PAIR_LEN
    } pair_t;

    typedef struct packed {
        op_t   op;
        pair_t pair;
        logic  first;
    } ctrl_t;

endpackage

/* hdl/eobd_cmpsub.sv */
// ----------------------------------------------------------------------------
// eobd_cmpsub
// shared compare and subtract unit for square root and division steps
// ----------------------------------------------------------------------------
module eobd_cmpsub #(
    parameter int WIDTH = 21
) (
    input  logic [WIDTH-1:0] cand,
    input  logic [WIDTH-1:0] trial,
    output logic             ge,
    output logic [WIDTH-1:0] diff
);

    assign ge   = (cand >= trial);
    assign diff = cand - trial;

endmodule

/* hdl/eobd_datapath.sv */
// ----------------------------------------------------------------------------
// eobd_datapath
// distance, square root and division registers around one shared unit
// ----------------------------------------------------------------------------
module eobd_datapath
    import eobd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 clk,
    input  ctrl_t                ctrl,
    input  logic [IN_DATA_W-1:0] in_points,
    output logic [Q16_W-1:0]     openness,
    output logic                 degenerate
);

    localparam int DW  = COORD_BITS + 5;     // q.4 distance width
    localparam int RW  = 2 * DW;             // radicand width, even
    localparam int PW2 = 2 * COORD_BITS;     // square width
    localparam int SW  = PW2 + 1;            // sum of squares width
    localparam int UW  = DW + 4;             // shared unit width

    logic [POINT_W-1:0]    pts_reg [NUM_POINTS];
    logic [PW2-1:0]        prod_reg;
    logic [PW2-1:0]        acc_reg;
    logic [RW-1:0]         rad_reg;
    logic [DW-1:0]         root_reg;
    logic [DW+1:0]         rem_reg;
    logic [DW-1:0]         d0_reg;
    logic [DW-1:0]         d1_reg;
    logic [DW-1:0]         len_reg;
    logic [DW-1:0]         hi_reg;
    logic [DW:0]           divrem_reg;
    logic [Q16_W-1:0]      q_reg;
    logic                  degen_reg;

    logic [POINT_W-1:0]    pa;
    logic [POINT_W-1:0]    pb;
    logic [POINT_W-1:0]    pa_sh;
    logic [POINT_W-1:0]    pb_sh;
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] mul_in;
    logic [PW2-1:0]        prod;
    logic [SW-1:0]         sq_sum;
    logic [RW-1:0]         rad_load;
    logic [DW:0]           hgt_sum;
    logic [DW-1:0]         height;
    logic [DW-1:0]         lo;
    logic [DW-1:0]         hi;
    logic [UW-1:0]         cand;
    logic [UW-1:0]         trial;
    logic                  ge;
    logic [UW-1:0]         diff;

    // point pair for the current distance
    always_comb
    begin
        case (ctrl.pair)
            PAIR_H1:
            begin
                pa = pts_reg[5];
                pb = pts_reg[1];
            end
            PAIR_H2:
            begin
                pa = pts_reg[4];
                pb = pts_reg[2];
            end
            default:
            begin
                pa = pts_reg[3];
                pb = pts_reg[0];
            end
        endcase
    end

    always_comb
    begin
        pa_sh  = pa >> COORD_BITS;
        pb_sh  = pb >> COORD_BITS;
        ax     = pa_sh[COORD_BITS-1:0];
        bx     = pb_sh[COORD_BITS-1:0];
        ay     = pa[COORD_BITS-1:0];
        by     = pb[COORD_BITS-1:0];
        dx     = (ax > bx) ? (ax - bx) : (bx - ax);
        dy     = (ay > by) ? (ay - by) : (by - ay);
        mul_in = (ctrl.op == OP_SQY) ? dy : dx;
        prod   = {{COORD_BITS{1'b0}}, mul_in} * {{COORD_BITS{1'b0}}, mul_in};
        sq_sum   = {1'b0, acc_reg} + {1'b0, prod_reg};
        rad_load = RW'(sq_sum) << 8;
    end

    // height average and min / max ordering
    always_comb
    begin
        hgt_sum = {1'b0, d0_reg} + {1'b0, d1_reg};
        height  = hgt_sum[DW:1];
        if (len_reg < height)
        begin
            lo = len_reg;
            hi = height;
        end
        else
        begin
            lo = height;
            hi = len_reg;
        end
    end

    // operands of the shared unit
    always_comb
    begin
        if (ctrl.op == OP_DIV)
        begin
            cand  = ctrl.first ? UW'(divrem_reg) : UW'({divrem_reg, 1'b0});
            trial = UW'(hi_reg);
        end
        else
        begin
            cand  = {rem_reg, rad_reg[RW-1 -: 2]};
            trial = UW'({root_reg, 2'b01});
        end
    end

    eobd_cmpsub #(
        .WIDTH (UW)
    ) u_cmpsub (
        .cand  (cand),
        .trial (trial),
        .ge    (ge),
        .diff  (diff)
    );

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_LOAD:
            begin
                for (int i = 0; i < NUM_POINTS; i++)
                begin
                    pts_reg[i] <= in_points[i*POINT_W +: POINT_W];
                end
            end
            OP_SQX:
            begin
                prod_reg <= prod;
            end
            OP_SQY:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= prod;
            end
            OP_SUM:
            begin
                rad_reg  <= rad_load;
                root_reg <= '0;
                rem_reg  <= '0;
            end
            OP_ROOT:
            begin
                rad_reg  <= rad_reg << 2;
                root_reg <= {root_reg[DW-2:0], ge};
                rem_reg  <= ge ? diff[DW+1:0] : cand[DW+1:0];
            end
            OP_STORE:
            begin
                case (ctrl.pair)
                    PAIR_H1: d0_reg  <= root_reg;
                    PAIR_H2: d1_reg  <= root_reg;
                    default: len_reg <= root_reg;
                endcase
            end
            OP_ORDER:
            begin
                hi_reg     <= hi;
                divrem_reg <= {1'b0, lo};
                q_reg      <= '0;
                degen_reg  <= (hi == '0);
            end
            OP_DIV:
            begin
                divrem_reg <= ge ? diff[DW:0] : cand[DW:0];
                q_reg      <= {q_reg[Q16_W-2:0], ge};
            end
            default:
            begin
            end
        endcase
    end

    assign openness   = degen_reg ? '0 : q_reg;
    assign degenerate = degen_reg;

endmodule

/* hdl/eobd_seq.sv */
// ----------------------------------------------------------------------------
// eobd_seq
// sequencer stepping the datapath through three roots and one division
// ----------------------------------------------------------------------------
module eobd_seq
    import eobd_pkg::*;
#(
    parameter int ROOT_STEPS = COORD_BITS_DEF + 5
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  slot_free,
    output ctrl_t ctrl,
    output logic  idle,
    output logic  done
);

    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);

    state_t             state_reg;
    state_t             state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    pair_t              pair_reg;
    pair_t              pair_next;
    op_t                op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            pair_reg  <= PAIR_H1;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pair_reg  <= pair_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pair_next  = pair_reg;
        op         = OP_NONE;
        idle       = 1'b0;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    op         = OP_LOAD;
                    pair_next  = PAIR_H1;
                    state_next = ST_SQX;
                end
            end
            ST_SQX:
            begin
                op         = OP_SQX;
                state_next = ST_SQY;
            end
            ST_SQY:
            begin
                op         = OP_SQY;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                op         = OP_SUM;
                step_next  = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                op = OP_ROOT;
                if (step_reg == ROOT_LAST)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_STORE:
            begin
                op = OP_STORE;
                case (pair_reg)
                    PAIR_H1:
                    begin
                        pair_next  = PAIR_H2;
                        state_next = ST_SQX;
                    end
                    PAIR_H2:
                    begin
                        pair_next  = PAIR_LEN;
                        state_next = ST_SQX;
                    end
                    default:
                    begin
                        state_next = ST_ORDER;
                    end
                endcase
            end
            ST_ORDER:
            begin
                op         = OP_ORDER;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                op = OP_DIV;
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ctrl.op    = op;
    assign ctrl.pair  = pair_reg;
    assign ctrl.first = (step_reg == '0);

endmodule

/* hdl/eye_openness_blink_detector_top.sv */
// ----------------------------------------------------------------------------
// eye_openness_blink_detector_top
// eye openness feature and per-eye blink detection from six landmarks
// ----------------------------------------------------------------------------
// Each request carries the six landmarks of one eye and an eye select. The
// block takes two vertical lid distances and one corner-to-corner distance in
// q.4 (floor of the square root of the squared distance times 256), averages
// the vertical pair into a height, and reports min over max of length and
// height in q1.16 (0 and degenerate set when both are zero). A feature below
// blink_threshold arms that eye; a feature at or above it, or a degenerate
// eye, raises blink if the eye was armed and disarms it. Each distance is
// the squaring of dx and dy, a sum, COORD_BITS+5 square root steps and a
// store, and the feature is an ordering step and 17 division steps, all on
// the one shared compare-subtract unit, then a hand-over of the result once
// the output slot is free. s_axis_tready is high only while the sequencer is
// idle; the result sits in an output register, so a new request can be taken
// while the previous result is still waiting on m_axis_tready.
// ----------------------------------------------------------------------------
module eye_openness_blink_detector_top
    import eobd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,

    // threshold register write, q1.16
    input  logic                  blink_threshold_we,
    input  logic [Q16_W-1:0]      blink_threshold,

    // request side
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // corner_left, lid_upper_left, lid_upper_right, corner_right,
    // lid_lower_right, lid_lower_left (24 bits each, low bits first)
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // eye_select
    input  logic [0:0]            s_axis_tuser,

    // result side
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // openness [16:0], blink [17], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // degenerate
    output logic [0:0]            m_axis_tuser
);

    localparam int PAD_W = OUT_DATA_W - Q16_W - 1;

    logic [Q16_W-1:0] thresh_reg;
    logic             eye_reg;
    logic [1:0]       armed_reg;
    logic [1:0]       armed_next;
    logic             out_valid_reg;
    logic [Q16_W-1:0] out_open_reg;
    logic             out_blink_reg;
    logic             out_degen_reg;

    logic             accept;
    logic             slot_free;
    logic             idle;
    logic             done;
    ctrl_t            ctrl;
    logic [Q16_W-1:0] openness;
    logic             degenerate;
    logic             closed;
    logic             blink_now;

    assign accept    = s_axis_tvalid && s_axis_tready;
    // output slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = idle;

    eobd_seq #(
        .ROOT_STEPS (COORD_BITS + 5)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_axis_tvalid),
        .slot_free (slot_free),
        .ctrl      (ctrl),
        .idle      (idle),
        .done      (done)
    );

    eobd_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .ctrl       (ctrl),
        .in_points  (s_axis_tdata),
        .openness   (openness),
        .degenerate (degenerate)
    );

    // degenerate eye counts as open
    assign closed    = !degenerate && (openness < thresh_reg);
    assign blink_now = !closed && armed_reg[eye_reg];

    always_comb
    begin
        armed_next = armed_reg;
        if (done)
        begin
            armed_next[eye_reg] = closed;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg    <= THRESH_RESET;
            armed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (blink_threshold_we)
            begin
                thresh_reg <= blink_threshold;
            end
            armed_reg <= armed_next;
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            eye_reg <= s_axis_tuser[0];
        end
        if (done)
        begin
            out_open_reg  <= openness;
            out_blink_reg <= blink_now;
            out_degen_reg <= degenerate;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_blink_reg, out_open_reg};
    assign m_axis_tuser  = out_degen_reg;

endmodule
